// File: hw/rtl/pms_pkg.sv
package pms_pkg;

    // request codes
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_LIST = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADSEL = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  stack_sel;
        logic [31:0] push_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_data;
        logic [4:0]  item_count;
        logic        last;
    } t_res;

endpackage

// File: hw/rtl/pms_store.sv
module pms_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/partitioned_multi_stack.sv
// Channel   Direction  Payload           Handshake
// request   in         pms_pkg::t_req    i_valid / o_stall
// result    out        pms_pkg::t_res    o_valid / i_stall
//
// A request is taken only while the sequencer is idle. Push, full, empty and
// bad stack number are answered from the execute state; a pop or a list first
// reads the top word from the registered store, then emits from the emit state,
// a list one word per cycle while the result is not stalled, top word first.
// Reset (synchronous, active low) empties every stack; the store itself is
// not cleared. A stalled result holds in the output register, and the
// sequencer waits on it before loading the next.
module partitioned_multi_stack #(
    parameter int unsigned NUM_STACKS  = 4,
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  pms_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output pms_pkg::t_res o_res
);

    localparam int unsigned STORE_WORDS = NUM_STACKS * STACK_DEPTH;
    localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [3:0]  NS4 = 4'(NUM_STACKS);
    localparam logic [LW-1:0] FULL_LVL = LW'(STACK_DEPTH);

    // one-hot sequencer: idle, execute, emit a word read from the store
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [1:0]      r_req_type;
    logic [SW-1:0]   r_sel;
    logic            r_bad;
    logic [LW-1:0]   r_lvl;     // fill level at acceptance
    logic [31:0]     r_push;
    logic [LW-1:0]   r_idx;     // offset of the word being read
    logic [LW-1:0]   r_cnt;     // count reported with emitted words

    logic [LW-1:0]   r_fill [NUM_STACKS];

    logic            r_out_valid;
    pms_pkg::t_res   r_out;

    logic            w_acc;
    logic            w_slot;
    logic            w_load;
    pms_pkg::t_res   w_res;
    logic            w_fill_we;
    logic [LW-1:0]   w_fill_val;
    logic            w_we, w_re;
    logic [AW-1:0]   w_base, w_waddr, w_raddr;
    logic [LW-1:0]   w_roff;
    logic            w_last;
    logic            w_idx_dec;
    logic            w_seed;
    logic [DATA_WIDTH-1:0] w_rdata;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    // output register free, or emptied this cycle
    assign w_slot  = !r_out_valid || !i_stall;

    assign w_base  = AW'(r_sel) * AW'(STACK_DEPTH);
    assign w_waddr = w_base + AW'(r_lvl);
    assign w_roff  = (r_state == S_EXEC) ? (r_lvl - LW'(1)) : (r_idx - LW'(1));
    assign w_raddr = w_base + AW'(w_roff);
    assign w_last  = (r_req_type == pms_pkg::REQ_POP) || (r_idx == '0);

    always_comb begin
        n_state    = r_state;
        w_load     = 1'b0;
        w_res      = '0;
        w_fill_we  = 1'b0;
        w_fill_val = r_lvl;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_idx_dec  = 1'b0;
        w_seed     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_req.req_type != pms_pkg::REQ_NONE)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_bad) begin
                    w_res = '{status: pms_pkg::ST_BADSEL, item_data: '0,
                              item_count: '0, last: 1'b1};
                    if (w_slot) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_req_type == pms_pkg::REQ_PUSH) begin
                    if (r_lvl >= FULL_LVL) begin
                        w_res = '{status: pms_pkg::ST_FULL, item_data: '0,
                                  item_count: 5'(r_lvl), last: 1'b1};
                    end else begin
                        w_res = '{status: pms_pkg::ST_OK, item_data: '0,
                                  item_count: 5'(r_lvl + LW'(1)), last: 1'b1};
                    end
                    if (w_slot) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                        if (r_lvl < FULL_LVL) begin
                            w_we       = 1'b1;
                            w_fill_we  = 1'b1;
                            w_fill_val = r_lvl + LW'(1);
                        end
                    end
                end else if (r_lvl == '0) begin
                    w_res = '{status: pms_pkg::ST_EMPTY, item_data: '0,
                              item_count: '0, last: 1'b1};
                    if (w_slot) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    // pop or list: fetch the top word
                    w_re    = 1'b1;
                    w_seed  = 1'b1;
                    n_state = S_EMIT;
                    if (r_req_type == pms_pkg::REQ_POP) begin
                        w_fill_we  = 1'b1;
                        w_fill_val = r_lvl - LW'(1);
                    end
                end
            end
            S_EMIT: begin
                w_res = '{status: pms_pkg::ST_OK, item_data: 32'(w_rdata),
                          item_count: 5'(r_cnt), last: w_last};
                if (w_slot) begin
                    w_load = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // next word down, read while this one leaves
                        w_re      = 1'b1;
                        w_idx_dec = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req_type <= i_req.req_type;
            r_sel      <= SW'(i_req.stack_sel);
            r_bad      <= ({1'b0, i_req.stack_sel} >= NS4);
            r_push     <= i_req.push_data;
            if ({1'b0, i_req.stack_sel} >= NS4) begin
                r_lvl <= '0;
            end else begin
                r_lvl <= r_fill[SW'(i_req.stack_sel)];
            end
        end
        if (w_seed) begin
            r_idx <= r_lvl - LW'(1);
            r_cnt <= (r_req_type == pms_pkg::REQ_POP) ? (r_lvl - LW'(1)) : r_lvl;
        end else if (w_idx_dec) begin
            r_idx <= r_idx - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (w_fill_we) begin
            r_fill[r_sel] <= w_fill_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // word store; the sequencer never writes and reads in one cycle
    pms_store #(
        .DEPTH (STORE_WORDS),
        .WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (DATA_WIDTH'(r_push)),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

`ifndef ASSERT_OFF
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("store written and read in one cycle");

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !r_bad) |-> (r_lvl <= FULL_LVL))
        else $error("fill level beyond stack depth");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < r_lvl))
        else $error("read offset outside the stack");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != pms_pkg::ST_OK) |-> o_res.last)
        else $error("error result not marked last");
`endif

endmodule
